>>> rtl/aik_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and step functions of the arm inverse kinematics pipeline.
// Used by aik_cordic and arm_inverse_kinematics; depends on nothing else.
package aik_pkg;

    localparam int unsigned ANGLE_ITERATIONS_DEF = 16;
    localparam int unsigned ATAN_TAB_LEN         = 24;

    // CORDIC vector width and angle accumulator width (Q3.28).
    localparam int unsigned CW = 36;
    localparam int unsigned AW = 32;

    typedef logic signed [CW-1:0] t_cvec;
    typedef logic signed [AW-1:0] t_angle;
    typedef logic signed [33:0]   t_wide;

    localparam t_angle PI_Q28      = 32'sd843314857;
    localparam t_wide  HALF_PI_Q28 = 34'sd421657428;
    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

    localparam t_angle ATAN_TAB [ATAN_TAB_LEN] = '{
        32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
        32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
        32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
        32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
        32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
        32'sd256,       32'sd128,       32'sd64,       32'sd32
    };

    typedef enum logic [0:0] {
        CFG_LINK_LENGTH = 1'b0,
        CFG_BASE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REACH_IN   = 2'd0,
        REACH_HIGH = 2'd1,
        REACH_LOW  = 2'd2
    } t_reach;

    // Per-item data that rides along the long arithmetic sections.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] dz;
        logic [31:0]        rr;
        logic signed [31:0] c;
        logic               flag;
    } t_side;

    typedef struct packed {
        logic [29:0] rem;
        logic [30:0] q;
        logic [28:0] den;
        logic        neg;
        t_reach      code;
        t_side       side;
    } t_div;

    typedef struct packed {
        logic [33:0] rem;
        logic [30:0] root;
    } t_sq;

    // One digit of a square root: takes the next two operand bits.
    function automatic t_sq sqrt_step(input t_sq a, input logic [1:0] b);
        logic [35:0] rem_sh;
        logic [35:0] trial;
        logic [35:0] diff;
        t_sq         r;
        rem_sh = {a.rem, b};
        trial  = {3'b000, a.root, 2'b01};
        diff   = rem_sh - trial;
        if (rem_sh >= trial) begin
            r.rem  = diff[33:0];
            r.root = {a.root[29:0], 1'b1};
        end else begin
            r.rem  = rem_sh[33:0];
            r.root = {a.root[29:0], 1'b0};
        end
        return r;
    endfunction

    // Q3.28 to Q3.13, halves rounded up.
    function automatic logic [16:0] round_q13(input t_wide a);
        t_wide t;
        t = a + 34'sd16384;
        return t[31:15];
    endfunction

endpackage

>>> rtl/aik_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC computing atan2(y, x) in Q3.28, one step per stage.
// Depends on aik_pkg.
module aik_cordic #(
    parameter int unsigned ITERATIONS = aik_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic           i_clk,
    input  aik_pkg::t_cvec i_y,
    input  aik_pkg::t_cvec i_x,
    output aik_pkg::t_angle o_angle
);
    import aik_pkg::*;

    t_cvec  r_x    [ITERATIONS+1];
    t_cvec  r_y    [ITERATIONS+1];
    t_angle r_acc  [ITERATIONS+1];
    logic   r_zero [ITERATIONS+1];

    // Left half-plane vectors are turned around and preloaded with +-pi.
    always_ff @(posedge i_clk) begin
        r_zero[0] <= (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            r_x[0]   <= -i_x;
            r_y[0]   <= -i_y;
            r_acc[0] <= (i_y >= 0) ? PI_Q28 : -PI_Q28;
        end else begin
            r_x[0]   <= i_x;
            r_y[0]   <= i_y;
            r_acc[0] <= '0;
        end
    end

    for (genvar i = 0; i < ITERATIONS; i++) begin : g_step
        always_ff @(posedge i_clk) begin
            r_zero[i+1] <= r_zero[i];
            if (r_y[i] > 0) begin
                r_x[i+1]   <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] - (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] + ATAN_TAB[i];
            end else begin
                r_x[i+1]   <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1]   <= r_y[i] + (r_x[i] >>> i);
                r_acc[i+1] <= r_acc[i] - ATAN_TAB[i];
            end
        end
    end

    assign o_angle = r_zero[ITERATIONS] ? '0 : r_acc[ITERATIONS];

endmodule

>>> rtl/arm_inverse_kinematics.sv
`timescale 1ns / 1ps
// Top level of the three-joint arm inverse kinematics pipeline.
// Depends on aik_pkg and aik_cordic.

// The block takes one target point per clock and never stalls: o_busy is always low, so
// every cycle with i_start high is an accepted beat. Each beat gives exactly one result
// beat, shown for one cycle with o_valid high. The pipeline is built around the 31-stage
// restoring divider for the acos argument, the 31-stage square-root pipeline, and the
// CORDIC stages, one per angle step. Results arrive in input order, and the receiver
// cannot hold them off. The link length and base height registers are written through
// i_cfg_we / i_cfg_idx / i_cfg_data and should only change while no beat is in flight.
module arm_inverse_kinematics #(
    parameter int unsigned ANGLE_ITERATIONS = aik_pkg::ANGLE_ITERATIONS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [15:0]  i_target_x,
    input  logic signed [15:0]  i_target_y,
    input  logic signed [15:0]  i_target_z,
    input  logic                i_cfg_we,
    input  aik_pkg::t_cfg_idx   i_cfg_idx,
    input  logic [13:0]         i_cfg_data,
    output logic                o_valid,
    output logic signed [16:0]  o_base_yaw,
    output logic signed [16:0]  o_shoulder_angle,
    output logic signed [16:0]  o_elbow_angle,
    output logic                o_out_of_reach
);
    import aik_pkg::*;

    localparam int unsigned DIV_STEPS  = 31;
    localparam int unsigned SQ_STEPS   = 31;
    localparam int unsigned CORDIC_LAT = ANGLE_ITERATIONS + 1;

    // Configuration registers.
    logic [13:0] r_link_length;
    logic [13:0] r_base_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_length <= 14'd6554;
            r_base_height <= 14'd1147;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINK_LENGTH: r_link_length <= i_cfg_data;
                CFG_BASE_HEIGHT: r_base_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // Stage 1: capture the point and take the height offset off z.
    logic               r_s1_v;
    logic signed [15:0] r_s1_x;
    logic signed [15:0] r_s1_y;
    logic signed [16:0] r_s1_dz;
    logic [13:0]        r_s1_l;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x  <= i_target_x;
        r_s1_y  <= i_target_y;
        r_s1_dz <= $signed({i_target_z[15], i_target_z}) - $signed({3'b000, r_base_height});
        r_s1_l  <= r_link_length;
    end

    // Stage 2: the squares.
    logic               r_s2_v;
    logic [30:0]        r_s2_xx;
    logic [30:0]        r_s2_yy;
    logic [31:0]        r_s2_dzz;
    logic [27:0]        r_s2_ll;
    logic signed [15:0] r_s2_x;
    logic signed [15:0] r_s2_y;
    logic signed [16:0] r_s2_dz;
    logic signed [31:0] n_xx;
    logic signed [31:0] n_yy;
    logic signed [33:0] n_dzz;

    always_comb begin
        n_xx  = r_s1_x * r_s1_x;
        n_yy  = r_s1_y * r_s1_y;
        n_dzz = r_s1_dz * r_s1_dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_xx  <= n_xx[30:0];
        r_s2_yy  <= n_yy[30:0];
        r_s2_dzz <= n_dzz[31:0];
        r_s2_ll  <= r_s1_l * r_s1_l;
        r_s2_x   <= r_s1_x;
        r_s2_y   <= r_s1_y;
        r_s2_dz  <= r_s1_dz;
    end

    // Stage 3: planar reach squared, distance squared and 2L^2.
    logic               r_s3_v;
    logic [31:0]        r_s3_rr;
    logic [32:0]        r_s3_d2;
    logic [28:0]        r_s3_den;
    logic signed [15:0] r_s3_x;
    logic signed [15:0] r_s3_y;
    logic signed [16:0] r_s3_dz;
    logic [31:0]        n_rr;

    assign n_rr = {1'b0, r_s2_xx} + {1'b0, r_s2_yy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_rr  <= n_rr;
        r_s3_d2  <= {1'b0, n_rr} + {1'b0, r_s2_dzz};
        r_s3_den <= {r_s2_ll, 1'b0};
        r_s3_x   <= r_s2_x;
        r_s3_y   <= r_s2_y;
        r_s3_dz  <= r_s2_dz;
    end

    // Stage 4: numerator of the acos argument and the reach check.
    t_div  r_div   [DIV_STEPS+1];
    logic  r_div_v [DIV_STEPS+1];
    t_div  n_div0;
    logic signed [33:0] n_num;
    logic signed [33:0] n_den_s;
    logic [33:0]        n_mag;

    always_comb begin
        n_den_s = $signed({5'b00000, r_s3_den});
        n_num   = $signed({1'b0, r_s3_d2}) - n_den_s;
        n_mag   = (n_num < 0) ? 34'(-n_num) : 34'(n_num);
        n_div0           = '0;
        n_div0.rem       = n_mag[29:0];
        n_div0.den       = r_s3_den;
        n_div0.neg       = n_num < 0;
        n_div0.side.x    = r_s3_x;
        n_div0.side.y    = r_s3_y;
        n_div0.side.dz   = r_s3_dz;
        n_div0.side.rr   = r_s3_rr;
        if (r_s3_den == '0) begin
            n_div0.code = REACH_HIGH;
        end else if (n_num > n_den_s) begin
            n_div0.code = REACH_HIGH;
        end else if (n_num < -n_den_s) begin
            n_div0.code = REACH_LOW;
        end else begin
            n_div0.code = REACH_IN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_v[0] <= 1'b0;
        end else begin
            r_div_v[0] <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div[0] <= n_div0;
    end

    // Restoring divider, one quotient bit per stage; the first stage takes bit 30,
    // which for an in-reach point is set only when the magnitude equals 2L^2.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [29:0] rem_t;
        t_div        n_d;

        always_comb begin
            if (k == 0) begin
                rem_t = r_div[k].rem;
            end else begin
                rem_t = {r_div[k].rem[28:0], 1'b0};
            end
            n_d = r_div[k];
            if (rem_t >= {1'b0, r_div[k].den}) begin
                n_d.rem = rem_t - {1'b0, r_div[k].den};
                n_d.q   = {r_div[k].q[29:0], 1'b1};
            end else begin
                n_d.rem = rem_t;
                n_d.q   = {r_div[k].q[29:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_div_v[k+1] <= 1'b0;
            end else begin
                r_div_v[k+1] <= r_div_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_div[k+1] <= n_d;
        end
    end

    // Stage 5: signed, clamped acos argument c in Q1.30 and its magnitude.
    logic        r_s5_v;
    t_side       r_s5_side;
    logic [30:0] r_s5_ac;
    t_side       n_s5_side;
    logic signed [31:0] n_qs;

    always_comb begin
        n_qs      = $signed({1'b0, r_div[DIV_STEPS].q});
        n_s5_side = r_div[DIV_STEPS].side;
        case (r_div[DIV_STEPS].code)
            REACH_HIGH: begin
                n_s5_side.c    = ONE_Q30;
                n_s5_side.flag = 1'b1;
            end
            REACH_LOW: begin
                n_s5_side.c    = -ONE_Q30;
                n_s5_side.flag = 1'b1;
            end
            default: begin
                n_s5_side.c    = r_div[DIV_STEPS].neg ? -n_qs : n_qs;
                n_s5_side.flag = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else begin
            r_s5_v <= r_div_v[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s5_side <= n_s5_side;
        r_s5_ac   <= (r_div[DIV_STEPS].code == REACH_IN) ? r_div[DIV_STEPS].q : 31'h4000_0000;
    end

    // Stage 6: c squared.
    logic        r_s6_v;
    t_side       r_s6_side;
    logic [61:0] r_s6_sq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6_side <= r_s5_side;
        r_s6_sq   <= r_s5_ac * r_s5_ac;
    end

    // Stage 7: the two square-root operands, 1 - c^2 in Q.60 and the planar reach squared in Q.28.
    t_sq         r_sq_s    [SQ_STEPS+1];
    t_sq         r_sq_r    [SQ_STEPS+1];
    logic [61:0] r_sq_os   [SQ_STEPS+1];
    logic [61:0] r_sq_or   [SQ_STEPS+1];
    t_side       r_sq_side [SQ_STEPS+1];
    logic        r_sq_v    [SQ_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_s[0]    <= '0;
        r_sq_r[0]    <= '0;
        r_sq_os[0]   <= 62'h1000_0000_0000_0000 - r_s6_sq;
        r_sq_or[0]   <= {2'b00, r_s6_side.rr, 28'h0};
        r_sq_side[0] <= r_s6_side;
    end

    // Two digit-by-digit square roots running side by side, one result bit per stage.
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_s[k+1]    <= sqrt_step(r_sq_s[k], r_sq_os[k][61-2*k -: 2]);
            r_sq_r[k+1]    <= sqrt_step(r_sq_r[k], r_sq_or[k][61-2*k -: 2]);
            r_sq_os[k+1]   <= r_sq_os[k];
            r_sq_or[k+1]   <= r_sq_or[k];
            r_sq_side[k+1] <= r_sq_side[k];
        end
    end

    // The four angles: base yaw, elbow, and the two shoulder terms.
    t_side  sq_end;
    t_cvec  yaw_y, yaw_x, elb_y, elb_x, sh1_y, sh1_x, sh2_y, sh2_x;
    t_angle yaw_a, elb_a, sh1_a, sh2_a;

    always_comb begin
        sq_end = r_sq_side[SQ_STEPS];
        yaw_y  = CW'(sq_end.y);
        yaw_x  = CW'(sq_end.x);
        elb_y  = $signed({5'b00000, r_sq_s[SQ_STEPS].root});
        elb_x  = CW'(sq_end.c);
        sh1_y  = $signed({5'b00000, r_sq_r[SQ_STEPS].root});
        sh1_x  = $signed({{5{sq_end.dz[16]}}, sq_end.dz, 14'h0});
        sh2_y  = CW'(sq_end.c) + CW'(ONE_Q30);
        sh2_x  = elb_y;
    end

    aik_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_y     (yaw_y),
        .i_x     (yaw_x),
        .o_angle (yaw_a)
    );

    aik_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic_elbow (
        .i_clk   (i_clk),
        .i_y     (elb_y),
        .i_x     (elb_x),
        .o_angle (elb_a)
    );

    aik_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic_reach (
        .i_clk   (i_clk),
        .i_y     (sh1_y),
        .i_x     (sh1_x),
        .o_angle (sh1_a)
    );

    aik_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic_link (
        .i_clk   (i_clk),
        .i_y     (sh2_y),
        .i_x     (sh2_x),
        .o_angle (sh2_a)
    );

    // Valid bit and reach flag travel alongside the CORDIC stages.
    logic r_cd_v    [CORDIC_LAT];
    logic r_cd_flag [CORDIC_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cd_v[0] <= 1'b0;
        end else begin
            r_cd_v[0] <= r_sq_v[SQ_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cd_flag[0] <= sq_end.flag;
    end

    for (genvar k = 1; k < CORDIC_LAT; k++) begin : g_cd_delay
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cd_v[k] <= 1'b0;
            end else begin
                r_cd_v[k] <= r_cd_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cd_flag[k] <= r_cd_flag[k-1];
        end
    end

    // Output stage: add the quarter turn to the yaw, form the shoulder difference,
    // and round all three angles to Q3.13.
    t_wide n_yaw;
    t_wide n_sh;
    t_wide n_elb;

    always_comb begin
        n_yaw = t_wide'(yaw_a) + HALF_PI_Q28;
        n_sh  = t_wide'(sh1_a) - t_wide'(sh2_a);
        n_elb = t_wide'(elb_a);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_cd_v[CORDIC_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_base_yaw       <= $signed(round_q13(n_yaw));
        o_shoulder_angle <= $signed(round_q13(n_sh));
        o_elbow_angle    <= $signed(round_q13(n_elb));
        o_out_of_reach   <= r_cd_flag[CORDIC_LAT-1];
    end

endmodule
